// ===== rtl/skv_pkg.sv =====
package skv_pkg;

   // Field widths fixed by the request and response words.
   localparam int KEY_BITS       = 32;
   localparam int REQ_VALUE_BITS = 32;
   localparam int STATUS_BITS    = 2;
   localparam int COUNT_OUT_BITS = 9;
   localparam int REQ_TDATA_BITS = 72;
   localparam int RSP_TDATA_BITS = 48;

   // Request kinds carried on req_tuser.
   localparam logic MODE_FIND = 1'b0;
   localparam logic MODE_ADD  = 1'b1;

   // Response status codes carried on rsp_tuser.
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EXISTS    = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_APPLY
   } skv_state_type;

   // Per-cell commands from the controller.
   typedef struct packed {
      logic cap_en;       // capture the compare flags for the held request key
      logic load_new;     // take the request key and value
      logic shift_in;     // take the left neighbor's key and value
      logic write_value;  // overwrite the value only
   } skv_cell_ctl_type;

   // Per-cell compare flags back to the controller.
   typedef struct packed {
      logic match;        // occupied and key equal to the request key
      logic ge;           // occupied and key not below the request key
   } skv_cell_flag_type;

endpackage

// ===== rtl/sorted_key_value_table.sv =====
// Channel   Direction  Handshake             Contents
// req_      in         req_tvalid/tready     tuser: mode; tdata: key, value, allow_update
// rsp_      out        rsp_tvalid/tready     tuser: status; tdata: found_value, entry_count
// csr_      in         csr_valid/csr_ready   csr_data: signed_keys
//
// A request passes a compare state, which captures the compare flags of every cell
// against the request key, then an apply state, which reduces them and applies the
// insert, update or read. The result is held in an output register, so a new word is
// taken while a finished result still waits; the next one can enter in the apply state.
// Reset is synchronous and clears the entry count, the key order setting and the
// handshake state; the key and value cells need no reset.
// A stalled response holds the block in its apply cycle until the slot frees up.
module sorted_key_value_table
   import skv_pkg::*;
#(
   parameter int ENTRIES    = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request: req_tuser[0] = mode (0 find, 1 add).
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,
   // Request: [31:0] key, [63:32] value, [64] allow_update, [71:65] zero.
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   // Response: rsp_tuser[1:0] = status.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [STATUS_BITS-1:0]    rsp_tuser,
   // Response: [31:0] found_value, [40:32] entry_count, [47:41] zero.
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   // Configuration: csr_data[0] = signed_keys.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);

   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int LEVELS     = $clog2(ENTRIES);
   localparam int VAL_WIDE   = (VALUE_BITS > REQ_VALUE_BITS) ? VALUE_BITS : REQ_VALUE_BITS;
   localparam int CNT_WIDE   = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;

   // Control state.
   skv_state_type         state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  signed_keys_ff;

   // Request held for the duration of its search.
   logic                  mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  upd_ff;
   logic [VAL_WIDE-1:0]   req_value_wide;

   // Response slot.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [REQ_VALUE_BITS-1:0] rsp_found_ff, rsp_found_in;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   // Cell row.
   skv_cell_ctl_type  cell_ctl  [ENTRIES];
   skv_cell_flag_type cell_flag [ENTRIES];
   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];

   logic [ENTRIES-1:0]    match_vec;
   logic [ENTRIES-1:0]    ge_vec;
   logic [ENTRIES-1:0]    prefix [LEVELS+1];
   logic [ENTRIES-1:0]    before_vec;
   logic [ENTRIES-1:0]    value_col [VALUE_BITS];
   logic [VALUE_BITS-1:0] hit_value;
   logic [VAL_WIDE-1:0]   hit_value_wide;
   logic [CNT_WIDE-1:0]   count_wide;

   logic req_accept;
   logic slot_free;
   logic finish;
   logic hit;
   logic table_full;
   logic do_insert;
   logic do_update;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_keys_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         signed_keys_ff <= csr_data;
      end
   end

   // The response slot is free when empty or being drained this cycle. The apply
   // cycle only finishes (and only then commits any change to the cells) once
   // the slot can take the result.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == S_APPLY) && slot_free;
   assign req_tready = (state_ff == S_IDLE) || finish;
   assign req_accept = req_tvalid && req_tready;

   assign req_value_wide = VAL_WIDE'(req_tdata[63:32]);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_tuser;
         key_ff   <= req_tdata[31:0];
         value_ff <= req_value_wide[VALUE_BITS-1:0];
         upd_ff   <= req_tdata[64];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (finish) begin
               state_in = req_accept ? S_CMP : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Gather the flags the cells captured in the compare cycle.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = cell_flag[i].match;
         ge_vec[i]    = cell_flag[i].ge;
      end
   end

   // Keys held are distinct, so at most one cell matches and the matching value
   // comes out of a plain OR over the masked values, one bit column at a time.
   always_comb begin
      for (int b = 0; b < VALUE_BITS; b++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            value_col[b][i] = match_vec[i] && cell_value[i][b];
         end
         hit_value[b] = |value_col[b];
      end
   end

   assign hit = |match_vec;

   // The insert point is the first occupied cell whose key is not below the new
   // key. A log-depth prefix OR tells each cell whether that point lies to its
   // left, in which case it takes its left neighbor's pair.
   always_comb begin
      prefix[0] = ge_vec;
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (i >= (1 << l)) begin
               prefix[l+1][i] = prefix[l][i] | prefix[l][i-(1<<l)];
            end else begin
               prefix[l+1][i] = prefix[l][i];
            end
         end
      end
      before_vec = {prefix[LEVELS][ENTRIES-2:0], 1'b0};
   end

   assign table_full = count_ff == COUNT_BITS'(ENTRIES);
   assign do_insert  = finish && (mode_ff == MODE_ADD) && !hit && !table_full;
   assign do_update  = finish && (mode_ff == MODE_ADD) && hit && upd_ff;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         cell_ctl[i].cap_en      = state_ff == S_CMP;
         cell_ctl[i].shift_in    = do_insert && before_vec[i] &&
                                   (COUNT_BITS'(i) <= count_ff);
         cell_ctl[i].load_new    = do_insert && !before_vec[i] &&
                                   (ge_vec[i] || (COUNT_BITS'(i) == count_ff));
         cell_ctl[i].write_value = do_update && match_vec[i];
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic [KEY_BITS-1:0]   left_key;
      logic [VALUE_BITS-1:0] left_value;

      if (g == 0) begin : g_head
         assign left_key   = '0;
         assign left_value = '0;
      end else begin : g_body
         assign left_key   = cell_key[g-1];
         assign left_value = cell_value[g-1];
      end

      skv_cell #(
         .INDEX      (g),
         .VALUE_BITS (VALUE_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl[g]),
         .signed_keys (signed_keys_ff),
         .used_count  (count_ff),
         .req_key     (key_ff),
         .req_value   (value_ff),
         .prev_key    (left_key),
         .prev_value  (left_value),
         .key_ff      (cell_key[g]),
         .value_ff    (cell_value[g]),
         .flag_ff     (cell_flag[g])
      );
   end

   assign count_in = do_insert ? count_ff + COUNT_BITS'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result of the request in its apply cycle.
   assign hit_value_wide = VAL_WIDE'(hit_value);
   assign count_wide     = CNT_WIDE'(count_in);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = '0;
         rsp_count_in = count_wide[COUNT_OUT_BITS-1:0];
         priority if (mode_ff == MODE_FIND) begin
            rsp_status_in = hit ? STATUS_OK : STATUS_NOT_FOUND;
            if (hit) begin
               rsp_found_in = hit_value_wide[REQ_VALUE_BITS-1:0];
            end
         end else if (hit) begin
            rsp_status_in = upd_ff ? STATUS_OK : STATUS_EXISTS;
         end else if (table_full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_found_ff};

   // Distinct keys mean the compare cycle can never flag two matching cells.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_APPLY |-> $onehot0(match_vec))
      else $error("more than one cell matches the request key");

   // The entry count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(ENTRIES))
      else $error("entry count exceeds table size");

   // The count grows by at most one per cycle and never shrinks.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("entry count moved by more than one");

   // A full report goes out only when the table really is full.
   a_full_report: assert property (@(posedge clock) disable iff (reset)
      finish && rsp_status_in == STATUS_FULL |-> table_full && !hit)
      else $error("full status with room left or a matching key");

   // An insert is never issued while a cell matches the request key.
   a_cell_cmd: assert property (@(posedge clock) disable iff (reset)
      do_insert |-> (before_vec & ~ge_vec & match_vec) == '0 && !hit)
      else $error("insert issued while a key matches");

endmodule

// ===== rtl/skv_cell.sv =====
module skv_cell
   import skv_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  skv_cell_ctl_type      ctl,
   input  logic                  signed_keys,
   input  logic [COUNT_BITS-1:0] used_count,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic [VALUE_BITS-1:0] prev_value,
   output logic [KEY_BITS-1:0]   key_ff,
   output logic [VALUE_BITS-1:0] value_ff,
   output skv_cell_flag_type     flag_ff
);

   logic                  occupied;
   logic [KEY_BITS-1:0]   cell_ord;
   logic [KEY_BITS-1:0]   req_ord;
   logic                  less;
   skv_cell_flag_type     flag_in;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_in;

   // Signed order is unsigned order with the sign bit flipped.
   always_comb begin
      occupied = COUNT_BITS'(INDEX) < used_count;
      cell_ord = {key_ff[KEY_BITS-1] ^ signed_keys, key_ff[KEY_BITS-2:0]};
      req_ord  = {req_key[KEY_BITS-1] ^ signed_keys, req_key[KEY_BITS-2:0]};
      less     = cell_ord < req_ord;
      flag_in.match = occupied && (key_ff == req_key);
      flag_in.ge    = occupied && !less;
   end

   always_comb begin
      priority if (ctl.load_new) begin
         key_in   = req_key;
         value_in = req_value;
      end else if (ctl.shift_in) begin
         key_in   = prev_key;
         value_in = prev_value;
      end else if (ctl.write_value) begin
         key_in   = key_ff;
         value_in = req_value;
      end else begin
         key_in   = key_ff;
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= '0;
      end else if (ctl.cap_en) begin
         flag_ff <= flag_in;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import skv_pkg::*;
;

   localparam int TABLE_DEPTH = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 20;

   // One response word, as carried on rsp_tuser and rsp_tdata.
   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [31:0]               found_value;
      logic [COUNT_OUT_BITS-1:0] entry_count;
   } rsp_word_type;

   // One row of the directed table. When typed is set, the response is the one
   // written in the row; otherwise the table predictor supplies it.
   typedef struct packed {
      logic                      mode;
      logic [31:0]               key;
      logic [31:0]               value;
      logic                      upd;
      logic                      typed;
      logic [STATUS_BITS-1:0]    exp_status;
      logic [31:0]               exp_value;
      logic [COUNT_OUT_BITS-1:0] exp_count;
   } directed_row_type;

   // The directed part starts from an empty table with unsigned key order. It
   // touches the key extremes, a miss on the empty table, duplicate adds with
   // and without update, a find that carries a value and an update flag, and a
   // new key added with the update flag set.
   localparam directed_row_type DIRECTED [0:16] = '{
      '{MODE_FIND, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, STATUS_NOT_FOUND, 32'h0, 9'd0},
      '{MODE_ADD,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, STATUS_OK, 32'h0, 9'd1},
      '{MODE_ADD,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, STATUS_OK, 32'h0, 9'd2},
      '{MODE_ADD,  32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, 1'b0, STATUS_OK, 32'h0, 9'd0},
      '{MODE_ADD,  32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, STATUS_OK, 32'h0, 9'd0},
      '{MODE_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, STATUS_OK, 32'hA5A5_A5A5, 9'd4},
      '{MODE_FIND, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, STATUS_OK, 32'h5A5A_5A5A, 9'd4},
      '{MODE_FIND, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, STATUS_OK, 32'hFFFF_FFFF, 9'd4},
      '{MODE_FIND, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, STATUS_OK, 32'h0, 9'd4},
      '{MODE_ADD,  32'h7FFF_FFFF, 32'h1234_5678, 1'b0, 1'b1, STATUS_EXISTS, 32'h0, 9'd4},
      '{MODE_ADD,  32'h7FFF_FFFF, 32'h1234_5678, 1'b1, 1'b1, STATUS_OK, 32'h0, 9'd4},
      '{MODE_FIND, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, STATUS_OK, 32'h1234_5678, 9'd4},
      '{MODE_FIND, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1, STATUS_NOT_FOUND, 32'h0, 9'd4},
      '{MODE_FIND, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 1'b1, STATUS_NOT_FOUND, 32'h0, 9'd4},
      '{MODE_ADD,  32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, STATUS_OK, 32'h0, 9'd0},
      '{MODE_ADD,  32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b0, 1'b0, STATUS_OK, 32'h0, 9'd0},
      '{MODE_FIND, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, 1'b0, STATUS_OK, 32'h0, 9'd0}
   };

   // Keys near the edges of both the signed and the unsigned order.
   localparam logic [31:0] EDGE_KEYS [0:7] = '{
      32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   // Every input of the block starts from a known value.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic                      req_tuser = MODE_FIND;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_data = 1'b0;

   // Idle rates in percent of cycles, changed between phases of the run.
   int tx_idle_pct = 36;
   int rx_idle_pct = 62;

   // The testbench's own image of the table: keys kept in the order the block
   // is meant to hold them, with their values, the count and the key order.
   logic [31:0] held_key [0:TABLE_DEPTH-1];
   logic [31:0] held_val [0:TABLE_DEPTH-1];
   int          held_count = 0;
   logic        keys_signed = 1'b0;

   // Responses still owed by the block, oldest first.
   rsp_word_type pending_rsp [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int checked_count  = 0;
   int sent_count     = 0;
   int add_count      = 0;
   int full_refusals  = 0;
   int exists_reports = 0;
   int updates_done   = 0;

   sorted_key_value_table #(
      .ENTRIES    (TABLE_DEPTH),
      .VALUE_BITS (32)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // True when key a orders strictly below key b under the current key order.
   function automatic logic key_below(input logic [31:0] a, input logic [31:0] b);
      return keys_signed ? ($signed(a) < $signed(b)) : (a < b);
   endfunction

   // Applies one request to the table image and returns the response it owes.
   // A find and a duplicate check both match by equality over every held entry,
   // so entries that were ordered under the other key order still hit. A new
   // key goes in before the first held key that does not order below it right now;
   // held entries are never reordered.
   function automatic rsp_word_type table_apply(input logic mode, input logic [31:0] key,
                                                input logic [31:0] value, input logic upd);
      rsp_word_type r;
      int           hit;
      int           slot;
      int           i;
      r = '0;
      r.status = STATUS_OK;
      hit = held_count;
      for (i = 0; i < held_count; i++)
         if (held_key[i] == key && hit == held_count) hit = i;
      if (mode == MODE_FIND) begin
         if (hit < held_count) r.found_value = held_val[hit];
         else r.status = STATUS_NOT_FOUND;
      end else if (hit < held_count) begin
         // A held key is handled this way even when the table is full.
         if (upd) held_val[hit] = value;
         else r.status = STATUS_EXISTS;
      end else if (held_count >= TABLE_DEPTH) begin
         // A new key does not fit: the table stays as it is.
         r.status = STATUS_FULL;
      end else begin
         slot = 0;
         while (slot < held_count && key_below(held_key[slot], key)) slot++;
         for (i = held_count; i > slot; i--) begin
            held_key[i] = held_key[i-1];
            held_val[i] = held_val[i-1];
         end
         held_key[slot] = key;
         held_val[slot] = value;
         held_count++;
      end
      r.entry_count = COUNT_OUT_BITS'(held_count);
      return r;
   endfunction

   // Offers one request word and returns at the falling edge after it was
   // taken. The valid stays high on return, so that back-to-back words see no
   // gap unless the next call chooses one; every assignment to the request
   // signals falls on a falling edge.
   task automatic send_word(input logic mode, input logic [31:0] key,
                            input logic [31:0] value, input logic upd,
                            input bit use_typed, input rsp_word_type typed);
      rsp_word_type predicted;
      int           count_before;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, upd, value, key};
      do @(posedge clock); while (req_tready !== 1'b1);
      count_before = held_count;
      predicted = table_apply(mode, key, value, upd);
      pending_rsp.push_back(use_typed ? typed : predicted);
      sent_count++;
      if (mode == MODE_ADD) add_count++;
      if (predicted.status == STATUS_FULL) full_refusals++;
      if (predicted.status == STATUS_EXISTS) exists_reports++;
      // An update is an add that succeeds without growing the table.
      if (mode == MODE_ADD && predicted.status == STATUS_OK &&
          held_count == count_before && upd) updates_done++;
      @(negedge clock);
   endtask

   // Drops the valid and holds the request side until every owed response
   // has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Writes the key order register; only called while the table is idle.
   task automatic write_key_order(input logic signed_order);
      csr_valid <= 1'b1;
      csr_data  <= signed_order;
      do @(posedge clock); while (csr_ready !== 1'b1);
      keys_signed = signed_order;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Picks a key: a held one in held_pct percent of cases so that finds hit
   // and adds collide, an edge key now and then, otherwise any 32-bit value.
   function automatic logic [31:0] pick_key(input int held_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < held_pct && held_count > 0)
         return held_key[$urandom_range(0, held_count - 1)];
      if (roll < held_pct + 12)
         return EDGE_KEYS[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic send_random(input int add_pct, input int held_pct);
      logic        mode;
      logic [31:0] key;
      mode = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_FIND;
      key  = pick_key(held_pct);
      send_word(mode, key, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
      // Now and then the sender holds off until the block has answered all.
      if ($urandom_range(0, 99) < 2) wait_drained();
   endtask

   // The receiver stalls at random; the rate follows the phase of the run.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Every response word taken is compared, field by field, with the oldest
   // owed response.
   always @(posedge clock) begin : check_rsp
      rsp_word_type seen;
      rsp_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen.status      = rsp_tuser;
         seen.found_value = rsp_tdata[31:0];
         seen.entry_count = rsp_tdata[40:32];
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response word: status %0d value %h count %0d",
                        seen.status, seen.found_value, seen.entry_count);
         end else begin
            want = pending_rsp.pop_front();
            checked_count++;
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"response %0d mismatch: expected status %0d value %h count %0d,",
                            " got status %0d value %h count %0d"}, checked_count,
                           want.status, want.found_value, want.entry_count,
                           seen.status, seen.found_value, seen.entry_count);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycle_count, pending_rsp.size());
         $display("sorted_key_value_table regression: fail");
         $finish;
      end
   end

   initial begin : run
      int past_full;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, unsigned key order straight after reset.
      foreach (DIRECTED[n])
         send_word(DIRECTED[n].mode, DIRECTED[n].key, DIRECTED[n].value, DIRECTED[n].upd,
                   DIRECTED[n].typed,
                   '{DIRECTED[n].exp_status, DIRECTED[n].exp_value, DIRECTED[n].exp_count});
      wait_drained();

      // Signed order over entries that were placed in unsigned order.
      write_key_order(1'b1);
      repeat (80) send_random(55, 35);
      wait_drained();

      // Idle rates swap, and the order goes back to unsigned.
      tx_idle_pct = 62;
      rx_idle_pct = 36;
      write_key_order(1'b0);
      repeat (80) send_random(55, 35);
      wait_drained();

      // No idling on either side. Almost only new keys go in until the table
      // is full; after that the run goes on with a good share of held keys, so
      // new keys are refused and held keys still get updated or reported.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_key_order(1'b1);
      past_full = 0;
      while (past_full < 40) begin
         if (held_count < TABLE_DEPTH) send_random(95, 5);
         else send_random(85, 40);
         if (held_count == TABLE_DEPTH) past_full++;
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d requests (%0d adds, %0d updates) in both key orders, table at %0d of %0d",
               sent_count, add_count, updates_done, held_count, TABLE_DEPTH);
      $display("%0d responses checked: %0d full refusals, %0d already-present, %0d mismatches",
               checked_count, full_refusals, exists_reports, mismatch_count);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("sorted_key_value_table regression: pass");
      end else begin
         $display("sorted_key_value_table regression: fail");
      end
      $finish;
   end

endmodule
